// ----- hw/rtl/prta_pkg.sv -----
// Shared types, constants and constant functions of the pressure to altitude block.
`default_nettype none
package prta_pkg;

    localparam int LOG_STEPS = 28;
    localparam int EXP_STEPS = 28;

    // Exponent of the pressure ratio in Q0.30 and the scale height in Q.8 metres.
    localparam logic [27:0] E30 = 28'd204293596;
    localparam logic [23:0] K8  = 24'd11348677;

    typedef struct packed {
        logic valid;
        logic err;
    } ctl_t;

    // Index of the highest set bit; zero for an operand of zero or one.
    function automatic logic [4:0] top_bit(input logic [23:0] x);
        logic [4:0] k;
        k = '0;
        for (int i = 0; i < 24; i++) begin
            if (x[i]) begin
                k = 5'(i);
            end
        end
        return k;
    endfunction

    // Integer square root, used only to build constants at elaboration.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] vv;
        logic [63:0] r;
        logic [63:0] b;
        vv = v;
        r  = '0;
        b  = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > vv) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (vv >= r + b) begin
                    vv = vv - (r + b);
                    r  = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Root of two taken idx+1 times, in Q1.30.
    function automatic logic [30:0] exp_coef(input int idx);
        logic [63:0] c;
        c = isqrt64(64'd1 << 61);
        for (int i = 0; i < idx; i++) begin
            c = isqrt64(c << 30);
        end
        return c[30:0];
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/prta_log2_unit.sv -----
// Pipelined base-two logarithm of the sample and the reference, one fraction bit a stage.
`default_nettype none
module prta_log2_unit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire prta_pkg::ctl_t  in_ctl,
    input  wire logic [23:0]     a_x,
    input  wire logic [23:0]     b_x,
    output prta_pkg::ctl_t       out_ctl,
    output logic      [32:0]     a_log,
    output logic      [32:0]     b_log
);
    import prta_pkg::*;

    logic [23:0] x_in [0:1];
    logic [30:0] m_reg    [0:LOG_STEPS][0:1];
    logic [27:0] frac_reg [0:LOG_STEPS][0:1];
    logic [4:0]  k_reg    [0:LOG_STEPS][0:1];
    logic [30:0] m_next    [0:LOG_STEPS][0:1];
    logic [27:0] frac_next [0:LOG_STEPS][0:1];
    logic [4:0]  k_next    [0:LOG_STEPS][0:1];
    ctl_t        ctl_reg [0:LOG_STEPS];

    assign x_in[0] = a_x;
    assign x_in[1] = b_x;

    always_comb begin
        logic [61:0] sq;
        logic [31:0] t;
        logic [30:0] xe;
        for (int l = 0; l < 2; l++) begin
            // Normalise so that the leading one sits at the unit position of Q1.30.
            k_next[0][l]    = top_bit(x_in[l]);
            xe              = {7'd0, x_in[l]};
            m_next[0][l]    = xe << (5'd30 - k_next[0][l]);
            frac_next[0][l] = '0;
            for (int s = 1; s <= LOG_STEPS; s++) begin
                sq = 62'(m_reg[s-1][l]) * 62'(m_reg[s-1][l]);
                t  = sq[61:30];
                m_next[s][l]    = t[31] ? t[31:1] : t[30:0];
                frac_next[s][l] = {frac_reg[s-1][l][26:0], t[31]};
                k_next[s][l]    = k_reg[s-1][l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s <= LOG_STEPS; s++) begin
                for (int l = 0; l < 2; l++) begin
                    m_reg[s][l]    <= m_next[s][l];
                    frac_reg[s][l] <= frac_next[s][l];
                    k_reg[s][l]    <= k_next[s][l];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= LOG_STEPS; s++) begin
                ctl_reg[s] <= '0;
            end
        end else if (en) begin
            ctl_reg[0] <= in_ctl;
            for (int s = 1; s <= LOG_STEPS; s++) begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    assign out_ctl = ctl_reg[LOG_STEPS];
    assign a_log   = {k_reg[LOG_STEPS][0], frac_reg[LOG_STEPS][0]};
    assign b_log   = {k_reg[LOG_STEPS][1], frac_reg[LOG_STEPS][1]};

endmodule
`default_nettype wire

// ----- hw/rtl/prta_exp2_unit.sv -----
// Pipelined power of two of a Q0.28 fraction, one fraction bit a stage.
`default_nettype none
module prta_exp2_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire prta_pkg::ctl_t    in_ctl,
    input  wire logic [27:0]       in_f,
    input  wire logic signed [5:0] in_n,
    output prta_pkg::ctl_t         out_ctl,
    output logic      [30:0]       out_acc,
    output logic signed [5:0]      out_n
);
    import prta_pkg::*;

    logic [30:0]        coef [0:EXP_STEPS-1];
    logic [30:0]        acc_reg  [0:EXP_STEPS];
    logic [27:0]        f_reg    [0:EXP_STEPS];
    logic signed [5:0]  n_reg    [0:EXP_STEPS];
    logic [30:0]        acc_next [1:EXP_STEPS];
    ctl_t               ctl_reg  [0:EXP_STEPS];

    for (genvar g = 0; g < EXP_STEPS; g++) begin : g_coef
        localparam logic [30:0] C = exp_coef(g);
        assign coef[g] = C;
    end

    always_comb begin
        logic [61:0] prod;
        for (int s = 1; s <= EXP_STEPS; s++) begin
            prod = 62'(acc_reg[s-1]) * 62'(coef[s-1]) + (62'd1 << 29);
            acc_next[s] = f_reg[s-1][27] ? prod[60:30] : acc_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg[0] <= 31'd1 << 30;
            f_reg[0]   <= in_f;
            n_reg[0]   <= in_n;
            for (int s = 1; s <= EXP_STEPS; s++) begin
                acc_reg[s] <= acc_next[s];
                f_reg[s]   <= {f_reg[s-1][26:0], 1'b0};
                n_reg[s]   <= n_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= EXP_STEPS; s++) begin
                ctl_reg[s] <= '0;
            end
        end else if (en) begin
            ctl_reg[0] <= in_ctl;
            for (int s = 1; s <= EXP_STEPS; s++) begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    assign out_ctl = ctl_reg[EXP_STEPS];
    assign out_acc = acc_reg[EXP_STEPS];
    assign out_n   = n_reg[EXP_STEPS];

endmodule
`default_nettype wire

// ----- hw/rtl/pressure_to_relative_altitude_top.sv -----
// Top level of the pressure to relative altitude converter.
`default_nettype none
// Converts a raw 24-bit pressure sample into a height in metres (signed Q23.8)
// relative to the reference pressure held in the configuration register, using
// the barometric formula in fixed point. The block is a single pipeline of 65
// register stages, and one request may enter in every clock cycle while the
// output is not stalled (the logarithm takes 29 stages, the exponent 29, and the
// difference, exponent product, integer and fraction split, shift, subtraction,
// scale multiply and output register seven).
// When a result waits and m_ready is low, the whole pipeline and s_ready hold,
// so nothing is lost. A zero sample or a zero reference gives a height of zero
// with the error flag set. The reference register is written through cfg_wr_en
// and should only be changed while no request is in flight.
module pressure_to_relative_altitude_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [23:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [23:0] s_raw_pressure,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [31:0] m_height_q8,
    output logic             m_height_error
);
    import prta_pkg::*;

    // The whole pipeline advances together whenever the output register can move.
    logic en;
    logic [23:0] ref_reg;

    ctl_t        log_ctl;
    logic [32:0] lp, lr;
    ctl_t        in_ctl;

    // Difference of logarithms as sign and magnitude.
    ctl_t        d_ctl_reg;
    logic        dneg_reg;
    logic [32:0] dmag_reg;

    // Product with the exponent.
    ctl_t        p_ctl_reg;
    logic        p_dneg_reg;
    logic [60:0] p_prod_reg;

    // Integer and fraction split of the exponent.
    ctl_t              r_ctl_reg;
    logic [27:0]       r_f_reg, r_f_next;
    logic signed [5:0] r_n_reg, r_n_next;

    ctl_t              e_ctl;
    logic [30:0]       e_acc;
    logic signed [5:0] e_n;

    ctl_t        v_ctl_reg;
    logic [45:0] v_reg, v_next;

    ctl_t        w_ctl_reg;
    logic        wneg_reg;
    logic [35:0] wmag_reg;

    // The scale multiply is split into two halves of the constant.
    ctl_t        k_ctl_reg;
    logic        k_neg_reg;
    logic [47:0] k_lo_reg, k_hi_reg;

    logic              out_valid_reg;
    logic signed [31:0] out_height_reg, height_next;
    logic              out_err_reg;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg <= 24'd4150272;
        end else if (cfg_wr_en) begin
            ref_reg <= cfg_wr_data;
        end
    end

    assign in_ctl.valid = s_valid;
    assign in_ctl.err   = (s_raw_pressure == 24'd0) || (ref_reg == 24'd0);

    prta_log2_unit u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (in_ctl),
        .a_x     (s_raw_pressure),
        .b_x     (ref_reg),
        .out_ctl (log_ctl),
        .a_log   (lp),
        .b_log   (lr)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            dneg_reg   <= lp < lr;
            dmag_reg   <= (lp < lr) ? lr - lp : lp - lr;
            p_dneg_reg <= dneg_reg;
            p_prod_reg <= 61'(dmag_reg) * 61'(E30);
            r_f_reg    <= r_f_next;
            r_n_reg    <= r_n_next;
            v_reg      <= v_next;
            wneg_reg   <= v_reg < (46'd1 << 30);
            wmag_reg   <= 36'((v_reg < (46'd1 << 30)) ? (46'd1 << 30) - v_reg
                                                      : v_reg - (46'd1 << 30));
            k_neg_reg  <= wneg_reg;
            k_lo_reg   <= 48'(wmag_reg) * 48'(K8[11:0]);
            k_hi_reg   <= 48'(wmag_reg) * 48'(K8[23:12]);
        end
    end

    // Round the scaled exponent to nearest, then take floor and fraction. A
    // negative exponent with a fraction borrows one from the integer part.
    always_comb begin
        logic [61:0] ysum;
        logic [31:0] ymag;
        logic        yneg;
        logic [27:0] fr;
        logic [5:0]  ip;
        ysum = 62'(p_prod_reg) + (62'd1 << 29);
        ymag = ysum[61:30];
        yneg = !p_dneg_reg && (ymag != 32'd0);
        fr   = ymag[27:0];
        ip   = {2'b00, ymag[31:28]};
        if (!yneg) begin
            r_n_next = signed'(ip);
            r_f_next = fr;
        end else if (fr != 28'd0) begin
            r_n_next = signed'(6'd0 - ip - 6'd1);
            r_f_next = 28'd0 - fr;
        end else begin
            r_n_next = signed'(6'd0 - ip);
            r_f_next = '0;
        end
    end

    prta_exp2_unit u_exp2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (r_ctl_reg),
        .in_f    (r_f_reg),
        .in_n    (r_n_reg),
        .out_ctl (e_ctl),
        .out_acc (e_acc),
        .out_n   (e_n)
    );

    // Apply the integer part of the exponent, rounding on a right shift.
    always_comb begin
        logic [3:0]  sh;
        logic [45:0] acc_ext;
        acc_ext = {15'd0, e_acc};
        if (e_n >= 0) begin
            sh     = e_n[3:0];
            v_next = acc_ext << sh;
        end else begin
            sh = 4'(6'd0 - 6'(unsigned'(e_n)));
            if (sh == 4'd0) begin
                v_next = acc_ext;
            end else begin
                v_next = (acc_ext + (46'd1 << (sh - 4'd1))) >> sh;
            end
        end
    end

    // Combine the partial products, round, apply the sign and clamp; an error gives zero.
    always_comb begin
        logic [59:0] sum;
        logic [31:0] hmag;
        sum  = 60'(k_lo_reg) + (60'(k_hi_reg) << 12) + (60'd1 << 29);
        hmag = {2'b00, sum[59:30]};
        if (k_neg_reg) begin
            height_next = (hmag > 32'h8000_0000) ? 32'sh8000_0000
                                                 : signed'(32'd0 - hmag);
        end else begin
            height_next = (hmag > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(hmag);
        end
        if (k_ctl_reg.err) begin
            height_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_ctl_reg     <= '0;
            p_ctl_reg     <= '0;
            r_ctl_reg     <= '0;
            v_ctl_reg     <= '0;
            w_ctl_reg     <= '0;
            k_ctl_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            d_ctl_reg     <= log_ctl;
            p_ctl_reg     <= d_ctl_reg;
            r_ctl_reg     <= p_ctl_reg;
            v_ctl_reg     <= e_ctl;
            w_ctl_reg     <= v_ctl_reg;
            k_ctl_reg     <= w_ctl_reg;
            out_valid_reg <= k_ctl_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_height_reg <= height_next;
            out_err_reg    <= k_ctl_reg.err;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_height_q8    = out_height_reg;
    assign m_height_error = out_err_reg;

endmodule
`default_nettype wire

// ----- sim/pressure_to_relative_altitude_top_test.sv -----
// Self-checking testbench for the pressure to relative altitude converter.
`default_nettype none
module pressure_to_relative_altitude_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import prta_pkg::*;

    // One expected result: the height in Q23.8 and the error flag.
    typedef struct {
        logic signed [31:0] height;
        logic               err;
    } height_t;

    // Works out the height for every accepted request and compares results in order.
    class altitude_scoreboard;
        logic [23:0] ref_pressure;
        logic [63:0] root_coef[EXP_STEPS];
        height_t     expected_heights[$];
        int          errors;
        int          checked;

        function new();
            ref_pressure = 24'd4150272;
            errors = 0;
            checked = 0;
            root_coef[0] = int_sqrt(64'd1 << 61);
            for (int i = 1; i < EXP_STEPS; i++) begin
                root_coef[i] = int_sqrt(root_coef[i-1] << 30);
            end
        endfunction

        // Bitwise square root; the operand stays below 2^62.
        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) begin
                    r = t;
                end
            end
            return r;
        endfunction

        // Base-two logarithm in Q5.28 by repeated squaring of the mantissa.
        function logic [63:0] log2_q28(logic [23:0] x);
            int          k;
            logic [63:0] m;
            logic [63:0] frac;
            k = 0;
            for (int i = 0; i < 24; i++) begin
                if (x[i]) begin
                    k = i;
                end
            end
            m = 64'(x) << (30 - k);
            frac = 0;
            for (int i = 0; i < LOG_STEPS; i++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    m = m >> 1;
                    frac = frac | 1;
                end
            end
            return (64'(k) << 28) | frac;
        endfunction

        function height_t altitude_of(logic [23:0] p);
            height_t     res;
            logic [63:0] lp, lr, dmag, ymag, f, fr, acc, v, wmag, hmag;
            logic        dneg, yneg, wneg;
            int          n, s;
            res.height = 0;
            res.err = 1'b0;
            if (p == 0 || ref_pressure == 0) begin
                res.err = 1'b1;
                return res;
            end
            lp = log2_q28(p);
            lr = log2_q28(ref_pressure);
            dneg = lp < lr;
            dmag = dneg ? lr - lp : lp - lr;
            ymag = (dmag * 64'(E30) + (64'd1 << 29)) >> 30;
            yneg = !dneg && ymag != 0;
            if (!yneg) begin
                n = int'(ymag >> 28);
                f = ymag & 64'hFFF_FFFF;
            end else begin
                fr = ymag & 64'hFFF_FFFF;
                n = -int'(ymag >> 28);
                f = 0;
                if (fr != 0) begin
                    n = n - 1;
                    f = (64'd1 << 28) - fr;
                end
            end
            // Fractional power of two, one root of two per set bit.
            acc = 64'd1 << 30;
            for (int k = EXP_STEPS - 1; k >= 0; k--) begin
                if (f[k]) begin
                    acc = (acc * root_coef[EXP_STEPS-1-k] + (64'd1 << 29)) >> 30;
                end
            end
            if (n >= 0) begin
                v = acc << (n & 15);
            end else begin
                s = (-n) & 15;
                v = (acc + (64'd1 << (s - 1))) >> s;
            end
            wneg = v < (64'd1 << 30);
            wmag = wneg ? (64'd1 << 30) - v : v - (64'd1 << 30);
            hmag = (wmag * 64'(K8) + (64'd1 << 29)) >> 30;
            if (wneg) begin
                res.height = (hmag > 64'd2147483648) ? 32'sh8000_0000 : -32'(hmag);
            end else begin
                res.height = (hmag > 64'd2147483647) ? 32'sh7FFF_FFFF : 32'(hmag);
            end
            return res;
        endfunction

        function void note_request(logic [23:0] p);
            expected_heights.push_back(altitude_of(p));
        endfunction

        function void check_result(logic signed [31:0] height, logic err);
            height_t e;
            if (expected_heights.size() == 0) begin
                $error("unexpected result: height_q8 %0d height_error %0b", height, err);
                errors++;
                return;
            end
            e = expected_heights.pop_front();
            checked++;
            if (height !== e.height) begin
                $error("height_q8 mismatch: expected %0d actual %0d", e.height, height);
                errors++;
            end
            if (err !== e.err) begin
                $error("height_error mismatch: expected %0b actual %0b", e.err, err);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [23:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [23:0]        s_raw_pressure;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_height_q8;
    logic               m_height_error;

    altitude_scoreboard sb = new();

    // Idling profile: 0 = sender seldom, receiver often; 1 = the reverse; 2 = none.
    int idle_mode;
    int requests_sent;
    int ref_writes;

    pressure_to_relative_altitude_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_pressure(s_raw_pressure),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_height_q8   (m_height_q8),
        .m_height_error(m_height_error)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Both handshakes are observed at the rising edge, before the block's own updates land.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_request(s_raw_pressure);
            requests_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_height_q8, m_height_error);
        end
    end

    // The receiver stalls at random according to the current profile.
    always @(negedge aclk) begin
        if (idle_mode == 0) begin
            m_ready <= ($urandom_range(99) >= 60);
        end else if (idle_mode == 1) begin
            m_ready <= ($urandom_range(99) >= 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offers one request and holds it until the block takes it. Any idle gap is
    // placed before valid is raised, so valid never drops while a request waits.
    task automatic send_request(input logic [23:0] p);
        int target;
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 6 : (idle_mode == 1) ? 60 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_pressure <= p;
        target = requests_sent + 1;
        @(negedge aclk);
        while (requests_sent < target) begin
            @(negedge aclk);
        end
    endtask

    // Lowers valid and waits until every expected result has come.
    task automatic drain;
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.expected_heights.size() != 0) begin
            @(negedge aclk);
        end
        repeat (80) @(negedge aclk);
    endtask

    // The reference is only changed while the block holds no request.
    task automatic write_reference(input logic [23:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.ref_pressure = value;
        ref_writes++;
    endtask

    // Mostly samples near the reference, as a sensor would give, with some spread
    // over the whole range and some very small values.
    function automatic logic [23:0] random_pressure(logic [23:0] r);
        int sel;
        int delta;
        sel = $urandom_range(9);
        if (sel < 5) begin
            delta = $urandom_range(8000) - 4000;
            return 24'(int'(r) + delta);
        end else if (sel < 8) begin
            return 24'($urandom);
        end else begin
            return 24'($urandom_range(300));
        end
    endfunction

    logic [23:0] ref_list[9];

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_raw_pressure = '0;
        m_ready = 1'b0;
        idle_mode = 0;
        requests_sent = 0;
        ref_writes = 0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part against the reset reference: range ends, zero sample,
        // a sample equal to the reference, neighbours and powers of two.
        send_request(24'd0);
        send_request(24'd1);
        send_request(24'hFF_FFFF);
        send_request(24'd4150272);
        send_request(24'd4150271);
        send_request(24'd4150273);
        send_request(24'h80_0000);
        send_request(24'h40_0000);
        send_request(24'd2);
        send_request(24'h7F_FFFF);
        send_request(24'hAA_AAAA);
        send_request(24'h55_5555);
        // A zero reference flags every sample, even a zero one.
        write_reference(24'd0);
        send_request(24'd0);
        send_request(24'd4150272);
        send_request(24'hFF_FFFF);
        // Smallest and largest references against the opposite ends.
        write_reference(24'd1);
        send_request(24'd1);
        send_request(24'hFF_FFFF);
        write_reference(24'hFF_FFFF);
        send_request(24'd1);
        send_request(24'hFF_FFFF);
        send_request(24'hFF_FFFE);

        ref_list = '{24'd4150272, 24'd1, 24'hFF_FFFF, 24'd0, 24'($urandom),
                     24'd4096000, 24'($urandom), 24'h80_0000, 24'd4150272};
        foreach (ref_list[i]) begin
            idle_mode = i / 3;
            write_reference(ref_list[i]);
            for (int j = 0; j < 185; j++) begin
                send_request(random_pressure(ref_list[i]));
                // Once in the middle the sender holds back until everything is out.
                if (i == 4 && j == 90) begin
                    drain();
                end
            end
        end

        drain();
        repeat (20) @(negedge aclk);
        if (sb.expected_heights.size() != 0) begin
            $error("%0d results never arrived", sb.expected_heights.size());
            sb.errors++;
        end
        $display("Covered %0d requests and %0d results over %0d reference settings,",
                 requests_sent, sb.checked, ref_writes);
        $display("including zero, extreme and equal pressures under three stall profiles.");
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
